[hw/rtl/ppc_pkg.sv]
// Shared types and constants for the perspective point projection and cull block.
// Used by ppc_div and perspective_point_project_cull; depends on nothing.
package ppc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_CAM_POS   = 3'd0;
    localparam logic [2:0] CFG_CAM_FWD   = 3'd1;
    localparam logic [2:0] CFG_CAM_RIGHT = 3'd2;
    localparam logic [2:0] CFG_CAM_UP    = 3'd3;
    localparam logic [2:0] CFG_FOCAL     = 3'd4;
    localparam logic [2:0] CFG_CENTRE_X  = 3'd5;
    localparam logic [2:0] CFG_HORIZON_Y = 3'd6;

    localparam int CFG_W = 60;

    // Divider sizing: numerators below 2^61, depth below 2^37, quotient clamped to 22 bits
    localparam int NUM_W = 61;
    localparam int DEN_W = 37;
    localparam int QUO_W = 22;
    localparam int REM_W = DEN_W + QUO_W;

    typedef logic [2:0][NUM_W-1:0] t_num3;
    typedef logic [2:0][QUO_W-1:0] t_quo3;

    // Per-transaction flags that ride alongside the divider
    typedef struct packed {
        logic u_zero;
        logic front;
        logic rad_nz;
        logic x_neg;
        logic x_nz;
        logic y_neg;
        logic y_nz;
    } t_side;

endpackage

[hw/rtl/ppc_div.sv]
// Pipelined restoring divider: three numerators over one shared depth, one quotient bit a stage.
// Quotients clamp to all ones on overflow. Depends on ppc_pkg.
module ppc_div
    import ppc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_num3            i_num,
    input  logic [DEN_W-1:0] i_den,
    input  t_side            i_side,
    output logic             o_valid,
    output t_quo3            o_quo,
    output t_side            o_side
);

    logic [QUO_W:0]     r_v;
    logic [REM_W-1:0]   r_rem [QUO_W+1][3];
    logic [QUO_W-1:0]   r_q   [QUO_W+1][3];
    logic [2:0]         r_ovf [QUO_W+1];
    logic [DEN_W-1:0]   r_den [QUO_W+1];
    t_side              r_side[QUO_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[QUO_W-1:0], i_valid};
        end
    end

    // Entry stage: flag quotients that do not fit
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_ovf[0][i] <= i_num[i] >= NUM_W'({i_den, {QUO_W{1'b0}}});
            r_rem[0][i] <= i_num[i][REM_W-1:0];
            r_q[0][i]   <= '0;
        end
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
    end

    for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
        localparam int K = QUO_W - j;
        logic [REM_W-1:0] n_sub;
        assign n_sub = REM_W'(r_den[j-1]) << K;

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                if (r_rem[j-1][i] >= n_sub) begin
                    r_rem[j][i] <= r_rem[j-1][i] - n_sub;
                    r_q[j][i]   <= r_q[j-1][i] | (QUO_W'(1) << K);
                end else begin
                    r_rem[j][i] <= r_rem[j-1][i];
                    r_q[j][i]   <= r_q[j-1][i];
                end
            end
            r_ovf[j]  <= r_ovf[j-1];
            r_den[j]  <= r_den[j-1];
            r_side[j] <= r_side[j-1];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_quo[i] = r_ovf[QUO_W][i] ? {QUO_W{1'b1}} : r_q[QUO_W][i];
        end
    end

    assign o_valid = r_v[QUO_W];
    assign o_side  = r_side[QUO_W];

endmodule

[hw/rtl/perspective_point_project_cull.sv]
// Top level: projects a scene point onto the window and culls it against the window edges.
// Depends on ppc_pkg and ppc_div.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+----------------------------------------------
//  point in  | start / busy          | i_point_x, i_point_y, i_point_z, i_bound_radius
//  result    | o_done (strobe)       | o_window_x, o_window_y, o_screen_radius, o_visible
//  config    | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// One transaction enters every cycle; busy is always low since no state is carried.
// The path runs through the dot product and numerator stages S1 to S9, the shared-depth
// divider (one quotient bit per stage), then FA and FB for offsets, culling, saturation.
// Synchronous active-low reset clears valid bits only; config registers take their defaults.
// The receiver cannot stall, so results leave on o_done and nothing is held back.
module perspective_point_project_cull
    import ppc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [19:0]  i_point_x,
    input  logic signed [19:0]  i_point_y,
    input  logic signed [19:0]  i_point_z,
    input  logic        [18:0]  i_bound_radius,
    input  logic                i_cfg_we,
    input  logic        [2:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output logic                o_done,
    output logic signed [15:0]  o_window_x,
    output logic signed [15:0]  o_window_y,
    output logic        [15:0]  o_screen_radius,
    output logic                o_visible
);

    // ---------------- configuration ----------------
    logic [59:0] r_cam_pos;
    logic [47:0] r_cam_fwd;
    logic [47:0] r_cam_right;
    logic [47:0] r_cam_up;
    logic [15:0] r_focal;
    logic [14:0] r_centre_x;
    logic [14:0] r_horizon_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_pos   <= '0;
            r_cam_fwd   <= 48'h4000_0000_0000;
            r_cam_right <= 48'h0000_0000_4000;
            r_cam_up    <= 48'h0000_4000_0000;
            r_focal     <= 16'd400;
            r_centre_x  <= 15'd1000;
            r_horizon_y <= 15'd300;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAM_POS:   r_cam_pos   <= i_cfg_data;
                CFG_CAM_FWD:   r_cam_fwd   <= i_cfg_data[47:0];
                CFG_CAM_RIGHT: r_cam_right <= i_cfg_data[47:0];
                CFG_CAM_UP:    r_cam_up    <= i_cfg_data[47:0];
                CFG_FOCAL:     r_focal     <= i_cfg_data[15:0];
                CFG_CENTRE_X:  r_centre_x  <= i_cfg_data[14:0];
                CFG_HORIZON_Y: r_horizon_y <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Unpack axes, read directly; user changes config only with pipe empty, unenforced
    logic signed [15:0] w_fwd   [3];
    logic signed [15:0] w_right [3];
    logic signed [15:0] w_up    [3];
    logic signed [19:0] w_cam   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_fwd[i]   = r_cam_fwd[16*i +: 16];
            w_right[i] = r_cam_right[16*i +: 16];
            w_up[i]    = r_cam_up[16*i +: 16];
            w_cam[i]   = r_cam_pos[20*i +: 20];
        end
    end

    assign busy = 1'b0;

    logic n_accept;
    assign n_accept = start & ~busy;

    // ---------------- valid chain for the front stages ----------------
    logic [8:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[7:0], n_accept};
        end
    end

    // S1: offset from camera
    logic signed [20:0] r1_rel [3];
    logic        [18:0] r1_rad;
    logic signed [19:0] n_pt   [3];

    assign n_pt[0] = i_point_x;
    assign n_pt[1] = i_point_y;
    assign n_pt[2] = i_point_z;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_rel[i] <= 21'(n_pt[i]) - 21'(w_cam[i]);
        end
        r1_rad <= i_bound_radius;
    end

    // S2: forward products
    logic signed [36:0] r2_pf  [3];
    logic signed [20:0] r2_rel [3];
    logic        [18:0] r2_rad;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_pf[i]  <= r1_rel[i] * w_fwd[i];
            r2_rel[i] <= r1_rel[i];
        end
        r2_rad <= r1_rad;
    end

    // S3: depth u in Q.14
    logic signed [37:0] r3_u;
    logic signed [20:0] r3_rel [3];
    logic        [18:0] r3_rad;

    always_ff @(posedge i_clk) begin
        r3_u   <= 38'(r2_pf[0]) + 38'(r2_pf[1]) + 38'(r2_pf[2]);
        r3_rel <= r2_rel;
        r3_rad <= r2_rad;
    end

    // S4: u times forward
    logic signed [53:0] r4_uf  [3];
    logic signed [20:0] r4_rel [3];
    logic signed [37:0] r4_u;
    logic        [18:0] r4_rad;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r4_uf[i] <= r3_u * w_fwd[i];
        end
        r4_rel <= r3_rel;
        r4_u   <= r3_u;
        r4_rad <= r3_rad;
    end

    // S5: perpendicular part, floored to Q.14
    logic signed [38:0] r5_perp [3];
    logic signed [37:0] r5_u;
    logic        [18:0] r5_rad;
    logic        [54:0] n5_diff [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_diff[i] = {{6{r4_rel[i][20]}}, r4_rel[i], 28'd0} - {r4_uf[i][53], r4_uf[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r5_perp[i] <= n5_diff[i][52:14];
        end
        r5_u   <= r4_u;
        r5_rad <= r4_rad;
    end

    // S6: projections onto right and up
    logic signed [54:0] r6_pr [3];
    logic signed [54:0] r6_pu [3];
    logic signed [37:0] r6_u;
    logic        [18:0] r6_rad;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r6_pr[i] <= r5_perp[i] * w_right[i];
            r6_pu[i] <= r5_perp[i] * w_up[i];
        end
        r6_u   <= r5_u;
        r6_rad <= r5_rad;
    end

    // S7: sum and floor offsets, take |u|, front test
    logic signed [56:0] n7_sx;
    logic signed [56:0] n7_sy;
    logic signed [41:0] r7_dx;
    logic signed [41:0] r7_dy;
    logic [DEN_W-1:0]   r7_au;
    logic        [18:0] r7_rad;
    logic               r7_u_zero;
    logic               r7_front;
    logic        [37:0] n7_neg_u;

    assign n7_sx    = 57'(r6_pr[0]) + 57'(r6_pr[1]) + 57'(r6_pr[2]);
    assign n7_sy    = 57'(r6_pu[0]) + 57'(r6_pu[1]) + 57'(r6_pu[2]);
    assign n7_neg_u = -r6_u;

    always_ff @(posedge i_clk) begin
        r7_dx     <= n7_sx[55:14];
        r7_dy     <= n7_sy[55:14];
        r7_au     <= r6_u[37] ? n7_neg_u[DEN_W-1:0] : r6_u[DEN_W-1:0];
        r7_u_zero <= (r6_u == '0);
        r7_front  <= r6_u >= $signed({5'd0, r6_rad, 14'd0});
        r7_rad    <= r6_rad;
    end

    // S8: numerators times focal distance
    logic signed [58:0] r8_nx;
    logic signed [58:0] r8_ny;
    logic        [34:0] r8_nd;
    logic [DEN_W-1:0]   r8_au;
    t_side              r8_side;

    always_ff @(posedge i_clk) begin
        r8_nx          <= r7_dx * $signed({1'b0, r_focal});
        r8_ny          <= r7_dy * $signed({1'b0, r_focal});
        r8_nd          <= r7_rad * r_focal;
        r8_au          <= r7_au;
        r8_side.u_zero <= r7_u_zero;
        r8_side.front  <= r7_front;
        r8_side.rad_nz <= (r7_rad != '0);
        r8_side.x_neg  <= r7_dx[41];
        r8_side.x_nz   <= (r7_dx != '0);
        r8_side.y_neg  <= r7_dy[41];
        r8_side.y_nz   <= (r7_dy != '0);
    end

    // S9: magnitudes scaled to Q.4 pixels
    t_num3            r9_num;
    logic [DEN_W-1:0] r9_au;
    t_side            r9_side;
    logic [58:0]      n9_mx;
    logic [58:0]      n9_my;

    assign n9_mx = r8_nx[58] ? 59'(-r8_nx) : r8_nx;
    assign n9_my = r8_ny[58] ? 59'(-r8_ny) : r8_ny;

    always_ff @(posedge i_clk) begin
        r9_num[0] <= {n9_mx[56:0], 4'd0};
        r9_num[1] <= {n9_my[56:0], 4'd0};
        r9_num[2] <= NUM_W'({r8_nd, 18'd0});
        r9_au     <= r8_au;
        r9_side   <= r8_side;
    end

    // ---------------- divide by |u| ----------------
    logic  w_div_v;
    t_quo3 w_quo;
    t_side w_div_side;

    ppc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[8]),
        .i_num   (r9_num),
        .i_den   (r9_au),
        .i_side  (r9_side),
        .o_valid (w_div_v),
        .o_quo   (w_quo),
        .o_side  (w_div_side)
    );

    // FA: apply signs, add view point
    logic               ra_v;
    logic signed [23:0] ra_wx4;
    logic signed [23:0] ra_wy4;
    logic        [21:0] ra_dim4;
    t_side              ra_side;
    logic signed [22:0] na_ox4;
    logic signed [22:0] na_oy4;

    assign na_ox4 = w_div_side.x_neg ? -$signed({1'b0, w_quo[0]}) : $signed({1'b0, w_quo[0]});
    assign na_oy4 = w_div_side.y_neg ? -$signed({1'b0, w_quo[1]}) : $signed({1'b0, w_quo[1]});

    always_ff @(posedge i_clk) begin
        ra_wx4  <= $signed({5'd0, r_centre_x, 4'd0}) + 24'(na_ox4);
        ra_wy4  <= $signed({5'd0, r_horizon_y, 4'd0}) - 24'(na_oy4);
        ra_dim4 <= w_quo[2];
        ra_side <= w_div_side;
    end

    // FB: cull against window edges, floor to pixels, saturate
    logic signed [24:0] nb_dim;
    logic signed [24:0] nb_wx_lo;
    logic signed [24:0] nb_wx_hi;
    logic signed [24:0] nb_wy_lo;
    logic signed [24:0] nb_wy_hi;
    logic signed [24:0] nb_w2;
    logic signed [24:0] nb_h2;
    logic               nb_vis;
    logic signed [15:0] nb_wx;
    logic signed [15:0] nb_wy;
    logic        [15:0] nb_sr;

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) begin
            return 16'sh7fff;
        end else if (v < -20'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[15:0];
        end
    endfunction

    always_comb begin
        nb_dim   = $signed({3'd0, ra_dim4});
        nb_wx_lo = 25'(ra_wx4) + nb_dim;
        nb_wx_hi = 25'(ra_wx4) - nb_dim;
        nb_wy_lo = 25'(ra_wy4) + nb_dim;
        nb_wy_hi = 25'(ra_wy4) - nb_dim;
        nb_w2    = $signed({5'd0, r_centre_x, 5'd0});
        nb_h2    = $signed({5'd0, r_horizon_y, 5'd0});
        nb_vis   = ra_side.front & ~ra_side.u_zero
                 & ~(nb_wx_lo < 0) & ~(nb_wx_hi > nb_w2)
                 & ~(nb_wy_lo < 0) & ~(nb_wy_hi > nb_h2);
        if (ra_side.u_zero) begin
            // Zero depth: pin to the edge in the offset's direction
            if (!ra_side.x_nz) begin
                nb_wx = $signed({1'b0, r_centre_x});
            end else if (ra_side.x_neg) begin
                nb_wx = 16'sh8000;
            end else begin
                nb_wx = 16'sh7fff;
            end
            if (!ra_side.y_nz) begin
                nb_wy = $signed({1'b0, r_horizon_y});
            end else if (ra_side.y_neg) begin
                nb_wy = 16'sh7fff;
            end else begin
                nb_wy = 16'sh8000;
            end
            nb_sr = ra_side.rad_nz ? 16'hffff : 16'h0000;
        end else begin
            nb_wx = sat16(ra_wx4[23:4]);
            nb_wy = sat16(ra_wy4[23:4]);
            nb_sr = (ra_dim4[21:20] != 2'b00) ? 16'hffff : ra_dim4[19:4];
        end
    end

    always_ff @(posedge i_clk) begin
        o_window_x      <= nb_wx;
        o_window_y      <= nb_wy;
        o_screen_radius <= nb_sr;
        o_visible       <= nb_vis;
    end

    // Valid bits of the final stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_v   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            ra_v   <= w_div_v;
            o_done <= ra_v;
        end
    end

endmodule

[tb/sv/perspective_point_project_cull_checker.sv]
// Checker for the perspective point projection and cull block: predicts each result.
// Depends on ppc_pkg; watches the point, config and result channels of the block.
module perspective_point_project_cull_checker
    import ppc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic signed [19:0]  i_point_x,
    input  logic signed [19:0]  i_point_y,
    input  logic signed [19:0]  i_point_z,
    input  logic        [18:0]  i_bound_radius,
    input  logic                i_cfg_we,
    input  logic        [2:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                o_done,
    input  logic signed [15:0]  o_window_x,
    input  logic signed [15:0]  o_window_y,
    input  logic        [15:0]  o_screen_radius,
    input  logic                o_visible,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic signed [15:0] wx;
        logic signed [15:0] wy;
        logic        [15:0] sr;
        logic               vis;
    } t_proj;

    logic [59:0] cam_pos;
    logic [47:0] cam_fwd, cam_rgt, cam_up;
    logic [15:0] focal;
    logic [14:0] centre_x, horizon;
    t_proj       proj_q[$];

    assign o_pending = proj_q.size();

    function automatic longint floor_div_pow2(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint axis_comp(logic [47:0] a, int k);
        logic signed [15:0] c;
        c = a[16*k +: 16];
        return longint'(c);
    endfunction

    function automatic t_proj project_point(logic signed [19:0] px, logic signed [19:0] py,
                                            logic signed [19:0] pz, logic [18:0] br);
        longint rel[3], perp[3];
        longint u, dx, dy, au, rad, z0, cx4, hy4, ox4, oy4, wx4, wy4, dim4;
        logic signed [19:0] cp;
        logic signed [19:0] pt[3];
        t_proj res;
        pt[0] = px; pt[1] = py; pt[2] = pz;
        u = 0; dx = 0; dy = 0;
        for (int i = 0; i < 3; i++) begin
            cp = cam_pos[20*i +: 20];
            rel[i] = longint'(pt[i]) - longint'(cp);
            u += rel[i] * axis_comp(cam_fwd, i);
        end
        for (int i = 0; i < 3; i++)
            perp[i] = floor_div_pow2(rel[i] * (64'sd1 <<< 28) - u * axis_comp(cam_fwd, i), 14);
        for (int i = 0; i < 3; i++) begin
            dx += perp[i] * axis_comp(cam_rgt, i);
            dy += perp[i] * axis_comp(cam_up, i);
        end
        dx = floor_div_pow2(dx, 14);
        dy = floor_div_pow2(dy, 14);
        rad = longint'(br);
        z0 = longint'(focal);
        cx4 = longint'(centre_x) * 16;
        hy4 = longint'(horizon) * 16;
        res.vis = 1'b0;
        if (u == 0) begin
            res.wx = dx > 0 ? 16'sh7fff : (dx < 0 ? 16'sh8000 : $signed({1'b0, centre_x}));
            res.wy = dy > 0 ? 16'sh8000 : (dy < 0 ? 16'sh7fff : $signed({1'b0, horizon}));
            res.sr = rad > 0 ? 16'hffff : 16'h0;
        end else begin
            au = u < 0 ? -u : u;
            ox4 = (dx * z0 * 16) / au;
            oy4 = (dy * z0 * 16) / au;
            dim4 = (rad * z0 * (64'sd1 <<< 18)) / au;
            wx4 = cx4 + ox4;
            wy4 = hy4 - oy4;
            // in front only when depth clears the radius, then test each window edge
            if (u >= rad * (64'sd1 <<< 14)) begin
                res.vis = 1'b1;
                if (wx4 + dim4 < 0 || wx4 - dim4 > 2 * cx4 ||
                    wy4 + dim4 < 0 || wy4 - dim4 > 2 * hy4)
                    res.vis = 1'b0;
            end
            res.wx = 16'(clamp(floor_div_pow2(wx4, 4), -32768, 32767));
            res.wy = 16'(clamp(floor_div_pow2(wy4, 4), -32768, 32767));
            res.sr = 16'(clamp(floor_div_pow2(dim4, 4), 0, 65535));
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_proj exp_r;
        if (!i_rst_n) begin
            cam_pos  <= '0;
            cam_fwd  <= 48'd16384 << 32;
            cam_rgt  <= 48'd16384;
            cam_up   <= 48'd16384 << 16;
            focal    <= 16'd400;
            centre_x <= 15'd1000;
            horizon  <= 15'd300;
            proj_q.delete();
            o_fail_count <= 0;
        end else begin
            // predict against the registers as they stand before this edge's write
            if (start && !busy)
                proj_q.push_back(project_point(i_point_x, i_point_y, i_point_z, i_bound_radius));
            if (o_done) begin
                if (proj_q.size() == 0) begin
                    $error("result with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = proj_q.pop_front();
                    if (o_window_x !== exp_r.wx || o_window_y !== exp_r.wy ||
                        o_screen_radius !== exp_r.sr || o_visible !== exp_r.vis)
                        o_fail_count <= o_fail_count + 1;
                    if (o_window_x !== exp_r.wx)
                        $error("window_x exp %0d got %0d", exp_r.wx, o_window_x);
                    if (o_window_y !== exp_r.wy)
                        $error("window_y exp %0d got %0d", exp_r.wy, o_window_y);
                    if (o_screen_radius !== exp_r.sr)
                        $error("screen_radius exp %0d got %0d", exp_r.sr, o_screen_radius);
                    if (o_visible !== exp_r.vis)
                        $error("visible exp %0d got %0d", exp_r.vis, o_visible);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAM_POS:   cam_pos  <= i_cfg_data[59:0];
                    CFG_CAM_FWD:   cam_fwd  <= i_cfg_data[47:0];
                    CFG_CAM_RIGHT: cam_rgt  <= i_cfg_data[47:0];
                    CFG_CAM_UP:    cam_up   <= i_cfg_data[47:0];
                    CFG_FOCAL:     focal    <= i_cfg_data[15:0];
                    CFG_CENTRE_X:  centre_x <= i_cfg_data[14:0];
                    CFG_HORIZON_Y: horizon  <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[tb/sv/perspective_point_project_cull_test.sv]
// Top of the testbench: drives camera settings and scene points into the block.
// Depends on ppc_pkg, the block and perspective_point_project_cull_checker.
module perspective_point_project_cull_test;
    import ppc_pkg::*;

    localparam int LATENCY  = 34;
    localparam int WDOG_MAX = 2000;

    // Index past the register list; writes there are dropped
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic               i_clk, i_rst_n, start, busy, i_cfg_we;
    logic signed [19:0] i_point_x, i_point_y, i_point_z;
    logic        [18:0] i_bound_radius;
    logic        [2:0]  i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               o_done, o_visible;
    logic signed [15:0] o_window_x, o_window_y;
    logic        [15:0] o_screen_radius;
    int                 fail_count, pending, idle_cycles, idle_pct;

    perspective_point_project_cull dut (.*);
    perspective_point_project_cull_checker u_check (.*, .o_fail_count(fail_count),
                                                    .o_pending(pending));

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Count cycles with no transaction in or out; bail out when it grows too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Hold the write enable high across back-to-back writes; the next point drops it.
    task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Hold the point on the ports until the block takes it, with random idle gaps first.
    task automatic send_point(logic signed [19:0] x, logic signed [19:0] y,
                              logic signed [19:0] z, logic [18:0] r);
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_point_x      <= x;
        i_point_y      <= y;
        i_point_z      <= z;
        i_bound_radius <= r;
        do @(posedge i_clk); while (busy);
    endtask

    // Let everything drain, then add latency so config writes land on an idle block.
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [47:0] axes(int ax, int ay, int az);
        logic [15:0] a, b, c;
        a = 16'(ax); b = 16'(ay); c = 16'(az);
        return {c, b, a};
    endfunction

    // Mostly small coordinates near a plausible camera, sometimes anything at all.
    task automatic random_point;
        logic signed [19:0] x, y, z;
        logic [18:0] r;
        if ($urandom_range(3) == 0) begin
            x = 20'($urandom); y = 20'($urandom); z = 20'($urandom); r = 19'($urandom);
        end else begin
            x = 20'($signed(20'($urandom_range(8191))) - 4096);
            y = 20'($signed(20'($urandom_range(8191))) - 4096);
            z = 20'($signed(20'($urandom_range(16383))) - 2048);
            r = 19'($urandom_range(255));
        end
        send_point(x, y, z, r);
    endtask

    task automatic random_config;
        int k;
        k = $urandom_range(3);
        write_reg(CFG_CAM_POS, k == 0 ? CFG_W'({$urandom, $urandom}) :
                  CFG_W'({20'($urandom_range(255)), 20'($urandom_range(255)),
                          20'($urandom_range(255))}));
        case (k)
            0: begin
                write_reg(CFG_CAM_FWD, CFG_W'({$urandom, $urandom}));
                write_reg(CFG_CAM_RIGHT, CFG_W'({$urandom, $urandom}));
                write_reg(CFG_CAM_UP, CFG_W'({$urandom, $urandom}));
            end
            1: begin
                write_reg(CFG_CAM_FWD, CFG_W'(axes(16384, 0, 0)));
                write_reg(CFG_CAM_RIGHT, CFG_W'(axes(0, 0, -16384)));
                write_reg(CFG_CAM_UP, CFG_W'(axes(0, 16384, 0)));
            end
            2: begin
                // 45 degree yaw, roughly unit
                write_reg(CFG_CAM_FWD, CFG_W'(axes(11585, 0, 11585)));
                write_reg(CFG_CAM_RIGHT, CFG_W'(axes(11585, 0, -11585)));
                write_reg(CFG_CAM_UP, CFG_W'(axes(0, 16384, 0)));
            end
            default: begin
                write_reg(CFG_CAM_FWD, CFG_W'(axes(0, 0, 16384)));
                write_reg(CFG_CAM_RIGHT, CFG_W'(axes(16384, 0, 0)));
                write_reg(CFG_CAM_UP, CFG_W'(axes(0, 16384, 0)));
            end
        endcase
        write_reg(CFG_FOCAL, k == 0 ? CFG_W'($urandom) : CFG_W'($urandom_range(1, 2000)));
        write_reg(CFG_CENTRE_X, k == 0 ? CFG_W'($urandom) : CFG_W'($urandom_range(32767)));
        write_reg(CFG_HORIZON_Y, k == 0 ? CFG_W'($urandom) : CFG_W'($urandom_range(32767)));
        write_reg(CFG_UNUSED, CFG_W'({$urandom, $urandom}));
    endtask

    initial begin
        start = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_point_x = '0; i_point_y = '0; i_point_z = '0; i_bound_radius = '0;
        idle_pct = 0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed with reset camera: extremes, behind camera, zero depth.
        send_point(0, 0, 1600, 16);
        send_point(20'sh7ffff, 20'sh7ffff, 20'sh7ffff, 19'h7ffff);
        send_point(20'sh80000, 20'sh80000, 20'sh80000, 19'h0);
        send_point(20'sh7ffff, 20'sh80000, 20'sh7ffff, 19'h1);
        send_point(160, -160, -1600, 16);
        send_point(160, -160, 0, 16);
        send_point(-160, 160, 0, 0);
        send_point(0, 0, 0, 0);
        send_point(0, 0, 0, 5);
        send_point(300000, 0, 100, 0);
        send_point(0, -300000, 100, 0);
        send_point(0, 0, 16, 3);
        drain();
        // Extreme registers: all ones, then zero focal and centres.
        write_reg(CFG_CAM_POS, '1);
        write_reg(CFG_CAM_FWD, '1);
        write_reg(CFG_CAM_RIGHT, '1);
        write_reg(CFG_CAM_UP, '1);
        write_reg(CFG_FOCAL, '1);
        write_reg(CFG_CENTRE_X, '1);
        write_reg(CFG_HORIZON_Y, '1);
        send_point(20'sh7ffff, 20'sh80000, 20'sh12345, 19'h7ffff);
        send_point(20'sh80000, 20'sh7ffff, 20'sh54321, 19'h2aaaa);
        send_point(0, 0, 0, 19'h55555);
        drain();
        write_reg(CFG_CAM_POS, '0);
        write_reg(CFG_CAM_FWD, CFG_W'(axes(0, 0, 16384)));
        write_reg(CFG_CAM_RIGHT, CFG_W'(axes(16384, 0, 0)));
        write_reg(CFG_CAM_UP, CFG_W'(axes(0, 16384, 0)));
        write_reg(CFG_FOCAL, '0);
        write_reg(CFG_CENTRE_X, '0);
        write_reg(CFG_HORIZON_Y, '0);
        send_point(160, 160, 1600, 16);
        send_point(-160, -160, 1600, 16);
        send_point(0, 0, 1600, 0);
        drain();

        // Random phases: cycle through the idle mixes under fresh camera settings.
        for (int ph = 0; ph < 16; ph++) begin
            random_config();
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 48;
                2: idle_pct = 0;
                default: idle_pct = 24;
            endcase
            repeat (96) random_point();
            drain();
        end

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
